// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL in this folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk_i edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clk_i edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/mhpq_pkg.sv =====
// ---------------------------------------------------------------------------
// mhpq_pkg
// Types, codes and control store of the max-heap priority queue.
// ---------------------------------------------------------------------------
package mhpq_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned ERR_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

  // Sequencer steps.
  typedef enum logic [3:0] {
    S_IDLE,
    S_PU_INC,
    S_PU_TEST,
    S_PU_CMP,
    S_PO_RD,
    S_PO_LD,
    S_SD_TEST,
    S_SD_CMP,
    S_HOLE,
    S_FINISH
  } step_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_DISPATCH,
    C_AT_ROOT,
    C_LE_PARENT,
    C_NO_KIDS,
    C_GE_CHILD,
    C_OUT_BUSY
  } cond_e;

  typedef enum logic [1:0] {
    RA_NONE,
    RA_PARENT,
    RA_KIDS,
    RA_LAST
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_PARENT,
    WR_CHILD,
    WR_HOLE
  } wr_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  // Key writes and the result load are suppressed when the branch is taken.
  typedef struct packed {
    cond_e   cond;
    step_e   tgt_t;
    step_e   tgt_f;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    cnt_op_e cnt_op;
    logic    ld_cur;
    logic    out_ld;
  } uword_t;

  function automatic uword_t ucode_rom(step_e step);
    uword_t w;
    w = '{cond: C_NEVER, tgt_t: S_IDLE, tgt_f: S_IDLE, rd_sel: RA_NONE,
          wr_sel: WR_NONE, cnt_op: CNT_HOLD, ld_cur: 1'b0, out_ld: 1'b0};
    case (step)
      S_IDLE: begin
        w.cond = C_DISPATCH;
      end
      S_PU_INC: begin
        w.cnt_op = CNT_INC;
        w.tgt_f  = S_PU_TEST;
      end
      S_PU_TEST: begin
        w.cond   = C_AT_ROOT;
        w.tgt_t  = S_HOLE;
        w.tgt_f  = S_PU_CMP;
        w.rd_sel = RA_PARENT;
      end
      S_PU_CMP: begin
        w.cond   = C_LE_PARENT;
        w.tgt_t  = S_HOLE;
        w.tgt_f  = S_PU_TEST;
        w.wr_sel = WR_PARENT;
      end
      S_PO_RD: begin
        w.rd_sel = RA_LAST;
        w.cnt_op = CNT_DEC;
        w.tgt_f  = S_PO_LD;
      end
      S_PO_LD: begin
        w.ld_cur = 1'b1;
        w.tgt_f  = S_SD_TEST;
      end
      S_SD_TEST: begin
        w.cond   = C_NO_KIDS;
        w.tgt_t  = S_HOLE;
        w.tgt_f  = S_SD_CMP;
        w.rd_sel = RA_KIDS;
      end
      S_SD_CMP: begin
        w.cond   = C_GE_CHILD;
        w.tgt_t  = S_HOLE;
        w.tgt_f  = S_SD_TEST;
        w.wr_sel = WR_CHILD;
      end
      S_HOLE: begin
        w.wr_sel = WR_HOLE;
        w.tgt_f  = S_FINISH;
      end
      S_FINISH: begin
        w.cond   = C_OUT_BUSY;
        w.tgt_t  = S_FINISH;
        w.tgt_f  = S_IDLE;
        w.out_ld = 1'b1;
      end
      default: begin
        w.tgt_f = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/mhpq_ifs.sv =====
// ---------------------------------------------------------------------------
// mhpq_ifs
// Valid/ready channels of the priority queue: request in, result out.
// ---------------------------------------------------------------------------
interface mhpq_req_if;
  logic                                valid;
  logic                                ready;
  logic [mhpq_pkg::CMD_W-1:0]          command;
  logic signed [mhpq_pkg::VALUE_W-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink (input valid, command, value, output ready);
endinterface

interface mhpq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [mhpq_pkg::VALUE_W-1:0] top_value;
  logic                                top_valid;
  logic [mhpq_pkg::COUNT_W-1:0]        count;
  logic [mhpq_pkg::ERR_W-1:0]          error;

  modport source (output valid, top_value, top_valid, count, error, input ready);
  modport sink (input valid, top_value, top_valid, count, error, output ready);
endinterface

// ===== rtl/core/max_heap_priority_queue.sv =====
// Binary max-heap priority queue. Each request pushes a key, pops the maximum
// or peeks, and yields one result with the maximum, a valid flag, the key count
// and an error code (pop on empty and push on full are refused and flagged).
// Keys sit in a single-write, dual-read memory of CAPACITY entries with
// registered read data; a microcoded sequencer moves a hole up or down the
// heap. Each heap level takes a memory read, then a compare and write. The
// last step waits while the previous result still sits unread in the output
// register. One request is in work at a time; a new request is taken while
// the previous result still waits in the output register. The key store needs
// no clearing after reset.
// ---------------------------------------------------------------------------
// max_heap_priority_queue
// Top level: sequencer, heap datapath and key memory.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module max_heap_priority_queue #(
  parameter int unsigned CAPACITY  = 1024,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mhpq_req_if.sink   req_i,
  mhpq_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W    = $clog2(CAPACITY);
  localparam int unsigned OUT_CNT_W = mhpq_pkg::COUNT_W;
  localparam int unsigned OUT_VAL_W = mhpq_pkg::VALUE_W;

  // Sequencer
  mhpq_pkg::step_e  upc_q, upc_d;
  mhpq_pkg::uword_t uw;
  logic             taken;
  logic             act;
  logic             in_fire;

  // Heap state
  logic [CNT_W-1:0]            count_q, count_d;
  logic [CNT_W-1:0]            pos_q, pos_d;
  logic signed [KEY_WIDTH-1:0] cur_q;
  logic signed [KEY_WIDTH-1:0] root_q;
  mhpq_pkg::err_e              err_q;

  // Key memory
  logic signed [KEY_WIDTH-1:0] mem [CAPACITY];
  logic signed [KEY_WIDTH-1:0] rd0_q, rd1_q;
  logic [ADDR_W-1:0]           ra0, ra1, wa;
  logic signed [KEY_WIDTH-1:0] wdata;
  logic                        wr_en;

  // Result register
  logic                        out_valid_q;
  logic signed [OUT_VAL_W-1:0] out_top_q;
  logic                        out_has_q;
  logic [OUT_CNT_W-1:0]        out_cnt_q;
  mhpq_pkg::err_e              out_err_q;

  // Datapath helpers
  logic signed [63:0]          val_ext;
  logic signed [KEY_WIDTH-1:0] key_in;
  logic signed [63:0]          root_ext;
  logic [CNT_W:0]              kid;
  logic [CNT_W-1:0]            parent;
  logic [CNT_W-1:0]            pos_m1;
  logic [CNT_W-1:0]            cnt_m1;
  logic [CNT_W:0]              kid_m1;
  logic [ADDR_W-1:0]           parent_addr;
  logic                        has_right;
  logic                        pick_right;
  logic signed [KEY_WIDTH-1:0] child;
  logic [CNT_W:0]              child_pos;
  logic                        out_busy;

  assign in_fire  = req_i.valid && req_i.ready;
  assign out_busy = out_valid_q && !rsp_o.ready;

  assign val_ext  = 64'($signed(req_i.value));
  assign key_in   = val_ext[KEY_WIDTH-1:0];
  assign root_ext = 64'(root_q);

  assign kid         = {pos_q, 1'b0};
  assign kid_m1      = kid - (CNT_W + 1)'(1);
  assign parent      = pos_q >> 1;
  assign parent_addr = ADDR_W'(parent - CNT_W'(1));
  assign pos_m1      = pos_q - CNT_W'(1);
  assign cnt_m1      = count_q - CNT_W'(1);
  assign has_right   = kid < {1'b0, count_q};
  assign pick_right  = has_right && (rd0_q < rd1_q);
  assign child       = pick_right ? rd1_q : rd0_q;
  assign child_pos   = kid + (CNT_W + 1)'(pick_right);

  // Control word and branch condition
  always_comb begin
    uw = mhpq_pkg::ucode_rom(upc_q);
    case (uw.cond)
      mhpq_pkg::C_NEVER:     taken = 1'b0;
      mhpq_pkg::C_DISPATCH:  taken = 1'b0;
      mhpq_pkg::C_AT_ROOT:   taken = (pos_q == CNT_W'(1));
      mhpq_pkg::C_LE_PARENT: taken = !(cur_q > rd0_q);
      mhpq_pkg::C_NO_KIDS:   taken = kid > {1'b0, count_q};
      mhpq_pkg::C_GE_CHILD:  taken = cur_q >= child;
      mhpq_pkg::C_OUT_BUSY:  taken = out_busy;
      default:               taken = 1'b0;
    endcase
    act = !taken;
  end

  // Next step
  always_comb begin
    upc_d = taken ? uw.tgt_t : uw.tgt_f;
    if (uw.cond == mhpq_pkg::C_DISPATCH) begin
      upc_d = mhpq_pkg::S_IDLE;
      if (in_fire) begin
        case (req_i.command)
          mhpq_pkg::CMD_PUSH: begin
            upc_d = (count_q == CNT_W'(CAPACITY)) ? mhpq_pkg::S_FINISH : mhpq_pkg::S_PU_INC;
          end
          mhpq_pkg::CMD_POP: begin
            upc_d = (count_q == '0) ? mhpq_pkg::S_FINISH : mhpq_pkg::S_PO_RD;
          end
          default: begin
            upc_d = mhpq_pkg::S_FINISH;
          end
        endcase
      end
    end
  end

  // Datapath controls
  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    ra0     = '0;
    ra1     = kid[ADDR_W-1:0];
    wa      = pos_m1[ADDR_W-1:0];
    wdata   = cur_q;
    wr_en   = 1'b0;

    case (uw.rd_sel)
      mhpq_pkg::RA_PARENT: ra0 = parent_addr;
      mhpq_pkg::RA_KIDS:   ra0 = kid_m1[ADDR_W-1:0];
      mhpq_pkg::RA_LAST:   ra0 = cnt_m1[ADDR_W-1:0];
      default:             ra0 = '0;
    endcase

    case (uw.cnt_op)
      mhpq_pkg::CNT_INC: begin
        count_d = count_q + CNT_W'(1);
        pos_d   = count_q + CNT_W'(1);
      end
      mhpq_pkg::CNT_DEC: begin
        count_d = cnt_m1;
        pos_d   = CNT_W'(1);
      end
      default: ;
    endcase

    if (act) begin
      case (uw.wr_sel)
        mhpq_pkg::WR_PARENT: begin
          wr_en = 1'b1;
          wdata = rd0_q;
          pos_d = parent;
        end
        mhpq_pkg::WR_CHILD: begin
          wr_en = 1'b1;
          wdata = child;
          pos_d = child_pos[CNT_W-1:0];
        end
        mhpq_pkg::WR_HOLE: begin
          wr_en = 1'b1;
          wdata = cur_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= mhpq_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q   <= upc_d;
      count_q <= count_d;
      if (uw.out_ld && act) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (in_fire) begin
      cur_q <= key_in;
      err_q <= mhpq_pkg::ERR_NONE;
      if (req_i.command == mhpq_pkg::CMD_PUSH && count_q == CNT_W'(CAPACITY)) begin
        err_q <= mhpq_pkg::ERR_FULL;
      end else if (req_i.command == mhpq_pkg::CMD_POP && count_q == '0) begin
        err_q <= mhpq_pkg::ERR_EMPTY;
      end
    end else if (uw.ld_cur) begin
      cur_q <= rd0_q;
    end
    if (wr_en && wa == '0) begin
      root_q <= wdata;
    end
    if (uw.out_ld && act) begin
      out_has_q <= (count_q != '0);
      out_top_q <= (count_q != '0) ? root_ext[OUT_VAL_W-1:0] : '0;
      out_cnt_q <= OUT_CNT_W'(count_q);
      out_err_q <= err_q;
    end
  end

  // Key memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wa] <= wdata;
    end
    rd0_q <= mem[ra0];
    rd1_q <= mem[ra1];
  end

  assign req_i.ready     = (upc_q == mhpq_pkg::S_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.top_value = out_top_q;
  assign rsp_o.top_valid = out_has_q;
  assign rsp_o.count     = out_cnt_q;
  assign rsp_o.error     = out_err_q;

  `ASSERT_CLK(a_count_bound, count_q <= CNT_W'(CAPACITY), "key count above capacity")
  `ASSERT_CLK(a_count_step, !$stable(count_q) |->
    (count_q == $past(count_q) + CNT_W'(1)) || (count_q == $past(count_q) - CNT_W'(1)),
    "key count moved by more than one")
  `ASSERT_CLK(a_write_in_heap,
    wr_en |-> (pos_q != '0) && ((pos_q <= count_q) || (pos_q == CNT_W'(1))),
    "key write outside heap")
  `ASSERT_CLK(a_result_load, (uw.out_ld && act) |=> out_valid_q, "finished request left no result")
  `ASSERT_ALWAYS(a_reset_idle,
    !rst_ni |=> (upc_q == mhpq_pkg::S_IDLE) && !out_valid_q,
    "sequencer busy in reset")

endmodule

// ===== tb/mhpq_tb_pkg.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mhpq_tb_pkg
// Heap tracker for the priority queue bench. It mirrors the key heap, queues
// the result each accepted request should produce and checks the results in
// order.
// ---------------------------------------------------------------------------
package mhpq_tb_pkg;
  import mhpq_pkg::*;

  localparam int unsigned HEAP_CAPACITY = 1024;

  typedef struct {
    logic signed [VALUE_W-1:0] top_value;
    logic                      top_valid;
    logic [COUNT_W-1:0]        count;
    err_e                      error;
  } heap_result_t;

  class heap_tracker;
    logic signed [VALUE_W-1:0] keys [1:HEAP_CAPACITY];
    int unsigned               held;
    int unsigned               mismatches;
    heap_result_t              expected_tops [$];

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_tops.size();
    endfunction

    task report(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    function void apply_request(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] value);
      heap_result_t              exp;
      int unsigned               pos;
      int unsigned               kid;
      logic signed [VALUE_W-1:0] tmp;
      exp.error = ERR_NONE;
      if (cmd == CMD_PUSH) begin
        if (held >= HEAP_CAPACITY) begin
          exp.error = ERR_FULL;
        end else begin
          held++;
          keys[held] = value;
          pos = held;
          while (pos > 1 && keys[pos] > keys[pos / 2]) begin
            tmp = keys[pos];
            keys[pos] = keys[pos / 2];
            keys[pos / 2] = tmp;
            pos = pos / 2;
          end
        end
      end else if (cmd == CMD_POP) begin
        if (held == 0) begin
          exp.error = ERR_EMPTY;
        end else begin
          keys[1] = keys[held];
          held--;
          pos = 1;
          kid = 2;
          // a lone left child at the last index is compared too
          while (kid <= held) begin
            if (kid + 1 <= held && keys[kid] < keys[kid + 1]) kid++;
            if (keys[pos] >= keys[kid]) break;
            tmp = keys[pos];
            keys[pos] = keys[kid];
            keys[kid] = tmp;
            pos = kid;
            kid = 2 * pos;
          end
        end
      end
      exp.top_valid = (held > 0);
      exp.top_value = (held > 0) ? keys[1] : '0;
      exp.count = held[COUNT_W-1:0];
      expected_tops.push_back(exp);
    endfunction

    task check_result(logic signed [VALUE_W-1:0] top_value, logic top_valid,
                      logic [COUNT_W-1:0] count, logic [ERR_W-1:0] error);
      heap_result_t exp;
      if (expected_tops.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      exp = expected_tops.pop_front();
      if (top_value !== exp.top_value)
        report($sformatf("top_value got %0d exp %0d", top_value, exp.top_value));
      if (top_valid !== exp.top_valid)
        report($sformatf("top_valid got %b exp %b", top_valid, exp.top_valid));
      if (count !== exp.count)
        report($sformatf("count got %0d exp %0d", count, exp.count));
      if (error !== exp.error)
        report($sformatf("error got %0d exp %0d", error, exp.error));
    endtask
  endclass

endpackage

// ===== tb/max_heap_priority_queue_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// max_heap_priority_queue_tb
// Drives push, pop and peek requests with bursty timing: a directed opening,
// churn on a small heap, a fill to capacity with refused pushes, then mixed
// traffic. The response side stalls on its own pattern and once holds off
// long enough to back the queue up. Every result is checked against a
// tracked copy of the heap.
// ---------------------------------------------------------------------------
module max_heap_priority_queue_tb;
  import mhpq_pkg::*;
  import mhpq_tb_pkg::*;

  localparam logic [CMD_W-1:0]          CMD_PEEK_ALIAS  = 2'd3;
  localparam logic signed [VALUE_W-1:0] KEY_MIN         = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] KEY_MAX         = 32'sh7fff_ffff;
  localparam int unsigned               HOLD_OFF_CYCLES = 400;
  localparam int unsigned               WATCHDOG_LIMIT  = 3000;
  localparam int unsigned               SETTLE_CYCLES   = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  mhpq_req_if req ();
  mhpq_rsp_if rsp ();

  max_heap_priority_queue #(
    .CAPACITY (HEAP_CAPACITY),
    .KEY_WIDTH(VALUE_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  heap_tracker tracker = new();
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  bit          rsp_hold_req = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
      tracker.check_result(rsp.top_value, rsp.top_valid, rsp.count, rsp.error);
    if ((req.valid === 1'b1 && req.ready === 1'b1) ||
        (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL max_heap_priority_queue");
      $finish;
    end
  end

  // response side stall pattern, with a long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned stretch;
    rsp.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      stretch = $urandom_range(10, 150);
      repeat (stretch) begin
        @(negedge clk_i);
        if (rsp_hold_req) begin
          rsp.ready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
          rsp_hold_req = 1'b0;
        end
        case (mode)
          0: rsp.ready <= 1'b1;
          1: rsp.ready <= $urandom_range(0, 1);
          2: rsp.ready <= ($urandom_range(0, 7) != 0);
          default: rsp.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic signed [VALUE_W-1:0] pick_key();
    int k;
    case ($urandom_range(0, 9))
      0: return KEY_MIN;
      1: return KEY_MAX;
      2, 3, 4: begin
        k = $urandom_range(0, 16);
        return k - 8;
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic offer(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] value);
    if (burst_left == 0) begin
      repeat (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8)) begin
        @(negedge clk_i);
        req.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk_i);
    req.valid <= 1'b1;
    req.command <= cmd;
    req.value <= value;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    tracker.apply_request(cmd, value);
    burst_left--;
  endtask

  task automatic random_request(int unsigned push_pct, int unsigned pop_pct);
    int unsigned      roll;
    logic [CMD_W-1:0] cmd;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      cmd = CMD_PUSH;
    end else if (roll < push_pct + pop_pct) begin
      cmd = CMD_POP;
    end else begin
      cmd = $urandom_range(0, 1) ? CMD_PEEK : CMD_PEEK_ALIAS;
    end
    offer(cmd, (cmd == CMD_PUSH) ? pick_key() : $urandom());
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    req.valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [CMD_W-1:0]          dir_cmd [23];
    logic signed [VALUE_W-1:0] dir_val [23];
    bit                        hold_issued;
    dir_cmd = '{CMD_PEEK, CMD_POP, CMD_PEEK_ALIAS,
                CMD_PUSH, CMD_PUSH, CMD_PUSH, CMD_PUSH, CMD_PUSH,
                CMD_PEEK_ALIAS, CMD_POP, CMD_POP, CMD_POP, CMD_POP, CMD_POP, CMD_POP,
                CMD_PUSH, CMD_PUSH, CMD_PUSH, CMD_PUSH, CMD_PUSH,
                CMD_POP, CMD_POP, CMD_PEEK};
    dir_val = '{0, 0, 0,
                KEY_MIN, KEY_MAX, 0, -1, KEY_MAX,
                -1, 0, 0, 0, 0, 0, 0,
                9, 8, 7, 6, 1,
                0, 0, 0};
    hold_issued = 1'b0;
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.command = CMD_PEEK;
    req.value = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty-heap refusals, extreme keys, duplicates, lone left child on pop
    foreach (dir_cmd[i]) offer(dir_cmd[i], dir_val[i]);

    repeat (100) random_request(50, 40);
    wait_all_results();

    while (tracker.held < HEAP_CAPACITY) begin
      if (!hold_issued && tracker.held >= HEAP_CAPACITY / 2) begin
        rsp_hold_req = 1'b1;
        hold_issued = 1'b1;
      end
      random_request(92, 4);
    end

    // around capacity: pushes on a full heap are refused
    repeat (30) random_request(60, 25);
    repeat (150) random_request(30, 60);

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("PASS max_heap_priority_queue");
    end else begin
      $display("FAIL max_heap_priority_queue");
    end
    $finish;
  end

endmodule
